[hdl/ttc_pkg.sv]
// ============================================================================
// ttc_pkg
// Shared types and constants for the text console cursor engine.
// ============================================================================
`default_nettype none

package ttc_pkg;

    // Character codes with a meaning of their own
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_NONE  = 8'h00;

    // Tab stops fall on multiples of this
    localparam int unsigned TAB_STEP = 8;
    localparam int unsigned TAB_BITS = $clog2(TAB_STEP);

    // Result kinds
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_SCROLL = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 3'd6;

    // Field widths
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned CPW_W      = 7;
    localparam int unsigned CPH_W      = 8;
    localparam int unsigned ORG_W      = 12;
    localparam int unsigned PITCH_W    = 15;
    localparam int unsigned ADDR_W     = 30;
    localparam int unsigned Y_W        = POS_W + CPH_W + 1;
    localparam int unsigned XO_W       = POS_W + CPW_W + 1;

    // Reset values of the configuration registers
    localparam logic [POS_W-1:0]   RST_NUM_COLS    = 8'd80;
    localparam logic [POS_W-1:0]   RST_NUM_ROWS    = 8'd30;
    localparam logic [CPW_W-1:0]   RST_CELL_WIDTH  = 7'd16;
    localparam logic [CPH_W-1:0]   RST_CELL_HEIGHT = 8'd32;
    localparam logic [ORG_W-1:0]   RST_LEFT_X      = 12'd0;
    localparam logic [ORG_W-1:0]   RST_TOP_Y       = 12'd0;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH  = 15'd1280;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_SCROLL_A,
        ST_SCROLL_B
    } ttc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch the incoming character
        logic step;        // update the cursor, latch the draw cell and scroll flag
        logic sel_scroll;  // work on the scroll cell rather than the draw cell
        logic addr_stage;  // load the first address stage
        logic load_out;    // load the result register
        logic last;        // mark the loaded result as the final one
    } ttc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic step_draw;    // this character draws a cell (valid in ST_STEP)
        logic step_scroll;  // this character scrolls (valid in ST_STEP)
        logic scroll_pend;  // latched scroll flag
        logic out_free;     // result register can take a new result
    } ttc_status_t;

endpackage

`default_nettype wire

[hdl/ttc_if.sv]
// ============================================================================
// ttc_if
// Channel interfaces: character input, result output, configuration writes.
// ============================================================================
`default_nettype none

interface ttc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ttc_result_if;
    logic        valid;
    logic        ready;
    logic        op_kind;
    logic [7:0]  glyph_code;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [29:0] cell_address;
    logic        last;

    modport source (output valid, output op_kind, output glyph_code, output cell_col,
                    output cell_row, output cell_address, output last, input ready);
    modport sink   (input valid, input op_kind, input glyph_code, input cell_col,
                    input cell_row, input cell_address, input last, output ready);
endinterface

interface ttc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [14:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/ttc_ctrl.sv]
// ============================================================================
// ttc_ctrl
// Sequencer: accepts a character, steps the cursor, then walks the draw
// and scroll results through the address stages to the result register.
// ============================================================================
`default_nettype none

module ttc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ttc_pkg::ttc_status_t status,
    output ttc_pkg::ttc_cmd_t         cmd
);

    ttc_pkg::ttc_state_t state_reg;
    ttc_pkg::ttc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ttc_pkg::ST_STEP;
                end
            end
            ttc_pkg::ST_STEP:
            begin
                if (status.step_draw)
                begin
                    state_next = ttc_pkg::ST_DRAW_A;
                end
                else if (status.step_scroll)
                begin
                    state_next = ttc_pkg::ST_SCROLL_A;
                end
                else
                begin
                    state_next = ttc_pkg::ST_IDLE;
                end
            end
            ttc_pkg::ST_DRAW_A:
            begin
                state_next = ttc_pkg::ST_DRAW_B;
            end
            ttc_pkg::ST_DRAW_B:
            begin
                if (status.out_free)
                begin
                    state_next = status.scroll_pend ? ttc_pkg::ST_SCROLL_A
                                                    : ttc_pkg::ST_IDLE;
                end
            end
            ttc_pkg::ST_SCROLL_A:
            begin
                state_next = ttc_pkg::ST_SCROLL_B;
            end
            ttc_pkg::ST_SCROLL_B:
            begin
                if (status.out_free)
                begin
                    state_next = ttc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ttc_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ttc_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
            end
            ttc_pkg::ST_DRAW_A:
            begin
                cmd.addr_stage = 1'b1;
            end
            ttc_pkg::ST_DRAW_B:
            begin
                cmd.load_out = status.out_free;
                cmd.last     = !status.scroll_pend;
            end
            ttc_pkg::ST_SCROLL_A:
            begin
                cmd.sel_scroll = 1'b1;
                cmd.addr_stage = 1'b1;
            end
            ttc_pkg::ST_SCROLL_B:
            begin
                cmd.sel_scroll = 1'b1;
                cmd.load_out   = status.out_free;
                cmd.last       = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ttc_datapath.sv]
// ============================================================================
// ttc_datapath
// Configuration registers, cursor, cursor step logic, two-stage cell address
// computation and the result register.
// ============================================================================
`default_nettype none

module ttc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration writes
    input  wire logic                                cfg_valid,
    input  wire logic [ttc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ttc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                     cfg_ready,
    // character in
    input  wire logic [ttc_pkg::CHAR_W-1:0]          char_code,
    // control
    input  wire ttc_pkg::ttc_cmd_t                   cmd,
    output ttc_pkg::ttc_status_t                     status,
    // result out
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     out_op_kind,
    output logic [ttc_pkg::CHAR_W-1:0]               out_glyph_code,
    output logic [ttc_pkg::POS_W-1:0]                out_cell_col,
    output logic [ttc_pkg::POS_W-1:0]                out_cell_row,
    output logic [ttc_pkg::ADDR_W-1:0]               out_cell_address,
    output logic                                     out_last
);

    localparam int unsigned PW = ttc_pkg::POS_W;

    // configuration
    logic [PW-1:0]                   num_cols_reg;
    logic [PW-1:0]                   num_rows_reg;
    logic [ttc_pkg::CPW_W-1:0]       cell_w_reg;
    logic [ttc_pkg::CPH_W-1:0]       cell_h_reg;
    logic [ttc_pkg::ORG_W-1:0]       left_x_reg;
    logic [ttc_pkg::ORG_W-1:0]       top_y_reg;
    logic [ttc_pkg::PITCH_W-1:0]     pitch_reg;

    // cursor and per-item state
    logic [PW-1:0]                   cur_col_reg;
    logic [PW-1:0]                   cur_row_reg;
    logic [ttc_pkg::CHAR_W-1:0]      code_reg;
    logic [PW-1:0]                   draw_col_reg;
    logic [PW-1:0]                   draw_row_reg;
    logic [ttc_pkg::CHAR_W-1:0]      draw_glyph_reg;
    logic                            scroll_reg;

    // address stages
    logic [ttc_pkg::Y_W-1:0]         y_reg;
    logic [ttc_pkg::XO_W-1:0]        xo_reg;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            op_kind_reg;
    logic [ttc_pkg::CHAR_W-1:0]      glyph_reg;
    logic [PW-1:0]                   col_out_reg;
    logic [PW-1:0]                   row_out_reg;
    logic [ttc_pkg::ADDR_W-1:0]      addr_out_reg;
    logic                            last_out_reg;

    // step logic
    logic [PW-1:0]                   cols_eff;
    logic [PW-1:0]                   rows_eff;
    logic [PW-1:0]                   last_col;
    logic [PW:0]                     col_p1;
    logic [PW:0]                     row_p1;
    logic [PW+1:0]                   tab_stop;
    logic [PW:0]                     ncol;
    logic [PW:0]                     nrow;
    logic                            chk;
    logic                            draw_c;
    logic [PW-1:0]                   draw_col_c;
    logic [ttc_pkg::CHAR_W-1:0]      draw_glyph_c;
    logic                            in_window;
    logic [PW:0]                     wcol;
    logic [PW:0]                     wrow;
    logic                            scroll_c;
    logic [PW-1:0]                   fin_row;

    // address selection
    logic [PW-1:0]                   sel_col;
    logic [PW-1:0]                   sel_row;
    logic [ttc_pkg::POS_W+ttc_pkg::CPH_W-1:0] row_px;
    logic [ttc_pkg::POS_W+ttc_pkg::CPW_W-1:0] col_px;
    logic [ttc_pkg::Y_W+ttc_pkg::PITCH_W-1:0] line_off;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= ttc_pkg::RST_NUM_COLS;
            num_rows_reg <= ttc_pkg::RST_NUM_ROWS;
            cell_w_reg   <= ttc_pkg::RST_CELL_WIDTH;
            cell_h_reg   <= ttc_pkg::RST_CELL_HEIGHT;
            left_x_reg   <= ttc_pkg::RST_LEFT_X;
            top_y_reg    <= ttc_pkg::RST_TOP_Y;
            pitch_reg    <= ttc_pkg::RST_LINE_PITCH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ttc_pkg::REG_NUM_COLS:    num_cols_reg <= cfg_data[PW-1:0];
                ttc_pkg::REG_NUM_ROWS:    num_rows_reg <= cfg_data[PW-1:0];
                ttc_pkg::REG_CELL_WIDTH:  cell_w_reg   <= cfg_data[ttc_pkg::CPW_W-1:0];
                ttc_pkg::REG_CELL_HEIGHT: cell_h_reg   <= cfg_data[ttc_pkg::CPH_W-1:0];
                ttc_pkg::REG_LEFT_X:      left_x_reg   <= cfg_data[ttc_pkg::ORG_W-1:0];
                ttc_pkg::REG_TOP_Y:       top_y_reg    <= cfg_data[ttc_pkg::ORG_W-1:0];
                ttc_pkg::REG_LINE_PITCH:  pitch_reg    <= cfg_data[ttc_pkg::PITCH_W-1:0];
                default:                  num_cols_reg <= num_cols_reg;
            endcase
        end
    end

    // A window size of zero acts as one
    assign cols_eff = (num_cols_reg == '0) ? PW'(1) : num_cols_reg;
    assign rows_eff = (num_rows_reg == '0) ? PW'(1) : num_rows_reg;
    assign last_col = cols_eff - PW'(1);
    assign col_p1   = {1'b0, cur_col_reg} + (PW+1)'(1);
    assign row_p1   = {1'b0, cur_row_reg} + (PW+1)'(1);
    // next tab stop above col+1
    assign tab_stop = {1'b0, col_p1[PW:ttc_pkg::TAB_BITS], ttc_pkg::TAB_BITS'(0)}
                      + (PW+2)'(ttc_pkg::TAB_STEP);
    assign in_window = (cur_col_reg < cols_eff) && (cur_row_reg < rows_eff);

    always_comb
    begin
        ncol         = {1'b0, cur_col_reg};
        nrow         = {1'b0, cur_row_reg};
        chk          = 1'b0;
        draw_c       = 1'b0;
        draw_col_c   = cur_col_reg;
        draw_glyph_c = code_reg;
        case (code_reg)
            ttc_pkg::CHR_CR:
            begin
                ncol = '0;
            end
            ttc_pkg::CHR_LF:
            begin
                ncol = '0;
                nrow = row_p1;
                chk  = 1'b1;
            end
            ttc_pkg::CHR_TAB:
            begin
                ncol = (tab_stop < {2'b00, last_col}) ? tab_stop[PW:0] : {1'b0, last_col};
                chk  = 1'b1;
            end
            ttc_pkg::CHR_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    ncol         = {1'b0, cur_col_reg - PW'(1)};
                    draw_col_c   = cur_col_reg - PW'(1);
                    draw_glyph_c = ttc_pkg::CHR_SPACE;
                    draw_c       = (draw_col_c < cols_eff) && (cur_row_reg < rows_eff);
                end
            end
            default:
            begin
                draw_c = in_window;
                ncol   = col_p1;
                chk    = 1'b1;
            end
        endcase
    end

    // Position check: wrap the column, then saturate the row with a scroll
    always_comb
    begin
        wcol     = ncol;
        wrow     = nrow;
        scroll_c = 1'b0;
        fin_row  = nrow[PW-1:0];
        if (chk)
        begin
            if (ncol >= {1'b0, cols_eff})
            begin
                wcol = '0;
                wrow = nrow + (PW+1)'(1);
            end
            if (wrow >= {1'b0, rows_eff})
            begin
                scroll_c = 1'b1;
                fin_row  = rows_eff - PW'(1);
            end
            else
            begin
                fin_row = wrow[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            scroll_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            cur_col_reg <= wcol[PW-1:0];
            cur_row_reg <= fin_row;
            scroll_reg  <= scroll_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg <= char_code;
        end
        if (cmd.step)
        begin
            draw_col_reg   <= draw_col_c;
            draw_row_reg   <= cur_row_reg;
            draw_glyph_reg <= draw_glyph_c;
        end
    end

    // Address stage one: pixel position of the cell
    assign sel_col = cmd.sel_scroll ? cur_col_reg : draw_col_reg;
    assign sel_row = cmd.sel_scroll ? cur_row_reg : draw_row_reg;
    assign row_px  = sel_row * cell_h_reg;
    assign col_px  = sel_col * cell_w_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.addr_stage)
        begin
            y_reg  <= ttc_pkg::Y_W'(row_px) + ttc_pkg::Y_W'(top_y_reg);
            xo_reg <= ttc_pkg::XO_W'(col_px) + ttc_pkg::XO_W'(left_x_reg);
        end
    end

    // Address stage two: line offset plus column offset, into the result
    assign line_off = y_reg * pitch_reg;

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            op_kind_reg  <= cmd.sel_scroll ? ttc_pkg::OP_SCROLL : ttc_pkg::OP_DRAW;
            glyph_reg    <= cmd.sel_scroll ? ttc_pkg::CHR_NONE : draw_glyph_reg;
            col_out_reg  <= sel_col;
            row_out_reg  <= sel_row;
            addr_out_reg <= line_off[ttc_pkg::ADDR_W-1:0]
                            + ttc_pkg::ADDR_W'(xo_reg);
            last_out_reg <= cmd.last;
        end
    end

    assign status.step_draw   = draw_c;
    assign status.step_scroll = scroll_c;
    assign status.scroll_pend = scroll_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_op_kind      = op_kind_reg;
    assign out_glyph_code   = glyph_reg;
    assign out_cell_col     = col_out_reg;
    assign out_cell_row     = row_out_reg;
    assign out_cell_address = addr_out_reg;
    assign out_last         = last_out_reg;

endmodule

`default_nettype wire

[hdl/text_terminal_cursor_engine_top.sv]
// ============================================================================
// text_terminal_cursor_engine_top
// Text console cursor engine: turns a character stream into cell draw and
// window scroll commands with framebuffer byte offsets.
// ============================================================================
//
//  Channel  | Direction | Transfer carries
//  ---------+-----------+---------------------------------------------------
//  char_in  | in        | char_code
//  cfg      | in        | index (register 0..6), data
//  result   | out       | op_kind, glyph_code, cell_col, cell_row,
//           |           | cell_address, last
//
// Sequence: a character is taken in ST_IDLE and stepped in ST_STEP; it then
// gives no result, one result, or a draw followed by a scroll. Each result
// passes through the address pipeline (cell pixel multiplies, then the
// line-pitch multiply) before it lands in the result register.
// Reset: rst_n clears the cursor to the top-left cell and loads the register
// defaults; no clearing pass, the block takes characters at once.
// Stalls: the result register holds a finished result while the next
// character is taken and stepped; the pipeline waits only when a new result
// would overwrite one not yet transferred.
// The configuration channel is always ready; write it only while idle.
// ============================================================================
`default_nettype none

module text_terminal_cursor_engine_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ttc_char_if.sink      char_in,
    ttc_cfg_if.sink       cfg,
    ttc_result_if.source  result
);

    // control and status between the sequencer and the datapath
    ttc_pkg::ttc_cmd_t    cmd;
    ttc_pkg::ttc_status_t status;

    // Sequencer: take a character when idle, then step it through
    ttc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: registers, cursor, address pipeline and result register
    ttc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .cfg_ready        (cfg.ready),
        .char_code        (char_in.char_code),
        .cmd              (cmd),
        .status           (status),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_op_kind      (result.op_kind),
        .out_glyph_code   (result.glyph_code),
        .out_cell_col     (result.cell_col),
        .out_cell_row     (result.cell_row),
        .out_cell_address (result.cell_address),
        .out_last         (result.last)
    );

endmodule

`default_nettype wire

[hdl/ttc_checker.sv]
// ============================================================================
// ttc_checker
// Port-level checks on the cursor engine, bound to the top level.
// ============================================================================
`default_nettype none

module ttc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_op_kind,
    input wire logic [7:0]  out_glyph_code,
    input wire logic [29:0] out_cell_address,
    input wire logic        out_last
);

    // one character at a time: no back-to-back input transfers
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a character is still in work");

    // a scroll is always the final result of its character
    a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_op_kind) |-> out_last)
        else $error("scroll result not marked last");

    // a scroll carries no glyph
    a_scroll_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_op_kind) |-> (out_glyph_code == 8'h00))
        else $error("scroll result carries a glyph");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_cell_address) && $stable(out_last)))
        else $error("stalled result changed");

endmodule

bind text_terminal_cursor_engine_top ttc_checker u_ttc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (char_in.valid),
    .in_ready         (char_in.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_op_kind      (result.op_kind),
    .out_glyph_code   (result.glyph_code),
    .out_cell_address (result.cell_address),
    .out_last         (result.last)
);

`default_nettype wire

[tb/text_terminal_cursor_engine_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// text_terminal_cursor_engine_top_tb
// Self-checking bench for the cursor engine: a scoreboard tracks the cursor
// and window settings, predicts every draw and scroll result with its byte
// offset, and checks the result channel under random idling on both sides.
// ============================================================================

module text_terminal_cursor_engine_top_tb;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int TAIL_CYCLES = 12;       // lets the slowest character, a draw then a scroll, finish
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 175;
    localparam int unsigned DW = ttc_pkg::CFG_DATA_W;

    // Index seven is not a register; writes to it must be dropped
    localparam logic [ttc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // One result as seen on the result channel
    typedef struct {
        logic                       op_kind;
        logic [7:0]                 glyph_code;
        logic [7:0]                 cell_col;
        logic [7:0]                 cell_row;
        logic [ttc_pkg::ADDR_W-1:0] cell_address;
        logic                       last;
    } cell_op_t;

    // ------------------------------------------------------------------------
    // Scoreboard: window settings, cursor, and the queue of results still due
    // ------------------------------------------------------------------------
    class cursor_scoreboard;
        logic [ttc_pkg::POS_W-1:0]   cols_reg;
        logic [ttc_pkg::POS_W-1:0]   rows_reg;
        logic [ttc_pkg::CPW_W-1:0]   cell_w;
        logic [ttc_pkg::CPH_W-1:0]   cell_h;
        logic [ttc_pkg::ORG_W-1:0]   origin_x;
        logic [ttc_pkg::ORG_W-1:0]   origin_y;
        logic [ttc_pkg::PITCH_W-1:0] pitch;
        logic [ttc_pkg::POS_W-1:0]   cur_col;
        logic [ttc_pkg::POS_W-1:0]   cur_row;
        cell_op_t                    due_q[$];
        int                          errors;

        function new();
            cols_reg = ttc_pkg::RST_NUM_COLS;
            rows_reg = ttc_pkg::RST_NUM_ROWS;
            cell_w   = ttc_pkg::RST_CELL_WIDTH;
            cell_h   = ttc_pkg::RST_CELL_HEIGHT;
            origin_x = ttc_pkg::RST_LEFT_X;
            origin_y = ttc_pkg::RST_TOP_Y;
            pitch    = ttc_pkg::RST_LINE_PITCH;
            cur_col  = '0;
            cur_row  = '0;
            errors   = 0;
        endfunction

        function void note_reg(logic [ttc_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
            case (idx)
                ttc_pkg::REG_NUM_COLS:    cols_reg = data[ttc_pkg::POS_W-1:0];
                ttc_pkg::REG_NUM_ROWS:    rows_reg = data[ttc_pkg::POS_W-1:0];
                ttc_pkg::REG_CELL_WIDTH:  cell_w   = data[ttc_pkg::CPW_W-1:0];
                ttc_pkg::REG_CELL_HEIGHT: cell_h   = data[ttc_pkg::CPH_W-1:0];
                ttc_pkg::REG_LEFT_X:      origin_x = data[ttc_pkg::ORG_W-1:0];
                ttc_pkg::REG_TOP_Y:       origin_y = data[ttc_pkg::ORG_W-1:0];
                ttc_pkg::REG_LINE_PITCH:  pitch    = data[ttc_pkg::PITCH_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_op(logic kind, logic [7:0] glyph,
                              logic [7:0] col, logic [7:0] row);
            cell_op_t    op;
            longint unsigned y;
            longint unsigned offset;
            y      = longint'(row) * cell_h + origin_y;
            offset = y * pitch + longint'(col) * cell_w + origin_x;
            op.op_kind      = kind;
            op.glyph_code   = glyph;
            op.cell_col     = col;
            op.cell_row     = row;
            op.cell_address = offset[ttc_pkg::ADDR_W-1:0];
            op.last         = 1'b0;
            due_q.push_back(op);
        endfunction

        // Step the cursor for one accepted character and queue its results
        function void note_char(logic [7:0] code);
            int unsigned cols;
            int unsigned rows;
            int unsigned col;
            int unsigned row;
            int unsigned stop;
            int          start_len;
            bit          check;
            bit          scroll;
            cols      = (cols_reg == 0) ? 1 : cols_reg;
            rows      = (rows_reg == 0) ? 1 : rows_reg;
            col       = cur_col;
            row       = cur_row;
            check     = 1'b0;
            scroll    = 1'b0;
            start_len = due_q.size();
            case (code)
                ttc_pkg::CHR_CR: col = 0;
                ttc_pkg::CHR_LF:
                begin
                    col   = 0;
                    row   = row + 1;
                    check = 1'b1;
                end
                ttc_pkg::CHR_TAB:
                begin
                    col   = col + 1;
                    stop  = col + ttc_pkg::TAB_STEP - (col % ttc_pkg::TAB_STEP);
                    col   = (stop < cols - 1) ? stop : cols - 1;
                    check = 1'b1;
                end
                ttc_pkg::CHR_BS:
                begin
                    // erase only inside the window; at column zero do nothing
                    if (col > 0)
                    begin
                        col = col - 1;
                        if (col < cols && row < rows)
                            push_op(ttc_pkg::OP_DRAW, ttc_pkg::CHR_SPACE, 8'(col), 8'(row));
                    end
                end
                default:
                begin
                    if (col < cols && row < rows)
                        push_op(ttc_pkg::OP_DRAW, code, 8'(col), 8'(row));
                    col   = col + 1;
                    check = 1'b1;
                end
            endcase
            if (check)
            begin
                if (col >= cols)
                begin
                    row = row + 1;
                    col = 0;
                end
                if (row >= rows)
                begin
                    row    = rows - 1;
                    scroll = 1'b1;
                end
            end
            cur_col = col[7:0];
            cur_row = row[7:0];
            if (scroll)
                push_op(ttc_pkg::OP_SCROLL, ttc_pkg::CHR_NONE, cur_col, cur_row);
            if (due_q.size() > start_len)
                due_q[due_q.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [29:0] want, logic [29:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_op(cell_op_t got);
            cell_op_t want;
            if (due_q.size() == 0)
            begin
                $display("%0t: result with none due: kind %0d glyph 0x%0h col %0d row %0d",
                         $time, got.op_kind, got.glyph_code, got.cell_col, got.cell_row);
                errors++;
                return;
            end
            want = due_q.pop_front();
            compare_field("op_kind",      want.op_kind,      got.op_kind);
            compare_field("glyph_code",   want.glyph_code,   got.glyph_code);
            compare_field("cell_col",     want.cell_col,     got.cell_col);
            compare_field("cell_row",     want.cell_row,     got.cell_row);
            compare_field("cell_address", want.cell_address, got.cell_address);
            compare_field("last",         want.last,         got.last);
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, block under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    ttc_char_if   char_ch ();
    ttc_cfg_if    cfg_ch ();
    ttc_result_if res_ch ();

    text_terminal_cursor_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_ch),
        .cfg     (cfg_ch),
        .result  (res_ch)
    );

    cursor_scoreboard sb = new();

    int gap_max;     // longest pause before a character, per phase
    int stall_max;   // longest hold of result ready low, per phase
    int hold_left;   // cycles of ready low still to serve
    int cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("text_terminal_cursor_engine_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check every transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_watch
        cell_op_t got;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.op_kind      = res_ch.op_kind;
            got.glyph_code   = res_ch.glyph_code;
            got.cell_col     = res_ch.cell_col;
            got.cell_row     = res_ch.cell_row;
            got.cell_address = res_ch.cell_address;
            got.last         = res_ch.last;
            sb.check_op(got);
        end
    end

    // Draw a fresh hold for ready after every transfer. Drawing the hold
    // straight after a transfer lets the stall land on any phase of the next
    // character's work, not just on a waiting result.
    initial
    begin : result_pacer
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                hold_left = $urandom_range(0, stall_max);
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------------

    // Offer one character after a random pause and hold it until the transfer.
    // Valid only drops when a pause is drawn, so back-to-back characters keep
    // it high without a second assignment in the same step.
    task automatic send_char(logic [7:0] code);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        sb.note_char(code);
    endtask

    // Drop valid, wait for every due result, then let a silent character finish
    task automatic settle();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ttc_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.note_reg(idx, data);
    endtask

    // Rewrite the whole window, plus one write to the unused index
    task automatic load_window(logic [DW-1:0] cols, logic [DW-1:0] rows,
                               logic [DW-1:0] cw, logic [DW-1:0] ch,
                               logic [DW-1:0] lx, logic [DW-1:0] ty,
                               logic [DW-1:0] lp);
        write_reg(ttc_pkg::REG_NUM_COLS, cols);
        write_reg(ttc_pkg::REG_NUM_ROWS, rows);
        write_reg(ttc_pkg::REG_CELL_WIDTH, cw);
        write_reg(ttc_pkg::REG_CELL_HEIGHT, ch);
        write_reg(REG_UNUSED, DW'($urandom_range(0, 32767)));
        write_reg(ttc_pkg::REG_LEFT_X, lx);
        write_reg(ttc_pkg::REG_TOP_Y, ty);
        write_reg(ttc_pkg::REG_LINE_PITCH, lp);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Window span: mostly small so wraps and scrolls come often
    function automatic logic [DW-1:0] pick_span();
        case ($urandom_range(0, 4))
            0: return DW'($urandom_range(1, 12));
            1: return DW'($urandom_range(1, 255));
            2: return DW'(255);
            3: return DW'(1);
            default: return DW'($urandom_range(13, 80));
        endcase
    endfunction

    // Idling level for a phase: none, light or full
    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 16;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] opening_text [14];
        logic [7:0] outside_text [6];
        logic [7:0] zero_text [5];
        int         r;
        logic [7:0] code;

        // reset window: glyph extremes, erase down to column zero and one
        // more, carriage return, tabs, line feed
        opening_text = '{8'h41, 8'hFF, ttc_pkg::CHR_NONE, ttc_pkg::CHR_BS,
                         ttc_pkg::CHR_BS, ttc_pkg::CHR_BS, ttc_pkg::CHR_BS,
                         ttc_pkg::CHR_CR, ttc_pkg::CHR_TAB, ttc_pkg::CHR_TAB,
                         ttc_pkg::CHR_LF, 8'h80, 8'h7F, ttc_pkg::CHR_TAB};
        // cursor left outside a shrunken window
        outside_text = '{ttc_pkg::CHR_BS, 8'h78, 8'h79, 8'h7A, ttc_pkg::CHR_LF,
                         ttc_pkg::CHR_TAB};
        // zero columns and rows act as one
        zero_text    = '{8'h61, ttc_pkg::CHR_TAB, ttc_pkg::CHR_LF, ttc_pkg::CHR_BS,
                         ttc_pkg::CHR_CR};

        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        gap_max           = 3;
        stall_max         = 3;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        foreach (opening_text[i])
            send_char(opening_text[i]);
        settle();

        load_window(2, 1, 16, 32, 0, 0, 1280);
        foreach (outside_text[i])
            send_char(outside_text[i]);
        settle();

        load_window(0, 0, 5, 9, 100, 200, 640);
        foreach (zero_text[i])
            send_char(zero_text[i]);
        settle();

        // Random part: one window per phase, the extremes first. A single
        // column with the largest cells walks the cursor down every row and
        // pushes the offset past thirty bits; zero sizes repeat addresses.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_window(1, 255, 127, 255, 4095, 4095, 32767);
                1: load_window(255, 255, 127, 255, 4095, 4095, 32767);
                2: load_window(1, 1, 0, 0, 0, 0, 0);
                default: load_window(pick_span(), pick_span(),
                                     DW'($urandom_range(0, 127)),
                                     DW'($urandom_range(0, 255)),
                                     DW'($urandom_range(0, 4095)),
                                     DW'($urandom_range(0, 4095)),
                                     DW'($urandom_range(0, 32767)));
            endcase
            gap_max   = pick_idle();
            stall_max = pick_idle();
            repeat (PHASE_ITEMS)
            begin
                // text-like stream: mostly printable, a fair share of
                // controls, and some bytes from the whole range
                r = $urandom_range(0, 99);
                if (r < 6)
                    code = ttc_pkg::CHR_CR;
                else if (r < 14)
                    code = ttc_pkg::CHR_LF;
                else if (r < 22)
                    code = ttc_pkg::CHR_TAB;
                else if (r < 32)
                    code = ttc_pkg::CHR_BS;
                else if (r < 85)
                    code = 8'($urandom_range(8'h20, 8'h7E));
                else
                    code = 8'($urandom_range(0, 255));
                send_char(code);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("text_terminal_cursor_engine_top: match");
        else
            $display("text_terminal_cursor_engine_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
hdl/ttc_pkg.sv
hdl/ttc_if.sv
hdl/ttc_ctrl.sv
hdl/ttc_datapath.sv
hdl/text_terminal_cursor_engine_top.sv
hdl/ttc_checker.sv
tb/text_terminal_cursor_engine_top_tb.sv
